FILE: hw/rtl/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared constants and types for the key/value line parser: store sizes,
// character codes, emit phase codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package kvlp_pkg;

  // Store sizes
  localparam int NAME_MAX  = 16;
  localparam int VALUE_MAX = 32;

  localparam int NAME_AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int VALUE_AW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
  localparam int NAME_LW  = $clog2(NAME_MAX + 1);
  localparam int VALUE_LW = $clog2(VALUE_MAX + 1);
  localparam int IDX_W    = (NAME_LW > VALUE_LW) ? NAME_LW : VALUE_LW;

  localparam logic [NAME_LW-1:0]  NAME_FULL_LEN  = NAME_LW'(NAME_MAX);
  localparam logic [VALUE_LW-1:0] VALUE_FULL_LEN = VALUE_LW'(VALUE_MAX);

  // Character codes
  localparam logic [7:0] CH_SUB  = 8'h1A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_US   = 8'h5F;

  // Emit phases
  localparam logic [2:0] PH_NAME = 3'd0;
  localparam logic [2:0] PH_EQ   = 3'd1;
  localparam logic [2:0] PH_VAL  = 3'd2;
  localparam logic [2:0] PH_CR   = 3'd3;
  localparam logic [2:0] PH_LF   = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic       name_first;  // write first name char, length 1
    logic       name_app;    // append name char
    logic       value_clr;   // start an empty value
    logic       value_app;   // append value byte
    logic       idx_clr;
    logic       idx_inc;
    logic       out_load;    // load output register with emit char
    logic [2:0] ph;          // current emit phase
  } kvlp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_crlf;
    logic is_sub;
    logic is_semi;
    logic is_eq;
    logic is_blank;     // space, tab, CR, LF
    logic is_name;
    logic name_full;
    logic value_empty;
    logic value_full;
    logic name_last;    // index on last name char
    logic value_last;   // index on last kept value char
    logic value_none;   // trimmed value is empty
    logic out_free;     // output register can take a beat
  } kvlp_stat_t;

endpackage

FILE: hw/rtl/kvlp_if.sv
// ----------------------------------------------------------------------------
// kvlp_if
// Valid/ready channels of the key/value line parser: input text beats and
// formatted output beats.
// ----------------------------------------------------------------------------
interface kvlp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface kvlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

FILE: hw/rtl/kvlp_dp.sv
// ----------------------------------------------------------------------------
// kvlp_dp
// Datapath: byte classifier, name and value stores with lengths, emit index
// and read registers, and the output register.
// ----------------------------------------------------------------------------
module kvlp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  kvlp_pkg::kvlp_cmd_t cmd,
  output kvlp_pkg::kvlp_stat_t st,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_last
);
  import kvlp_pkg::*;

  logic [7:0]          name_mem  [NAME_MAX];
  logic [7:0]          value_mem [VALUE_MAX];
  logic [NAME_LW-1:0]  name_len_r;
  logic [VALUE_LW-1:0] value_len_r;
  logic [VALUE_LW-1:0] vtrim_r;     // length up to last non-blank kept byte
  logic [IDX_W-1:0]    idx_r;
  logic [7:0]          name_rd_r;
  logic [7:0]          value_rd_r;
  logic                out_valid_r;
  logic [7:0]          out_char_r;
  logic                out_last_r;
  logic [7:0]          up_byte;
  logic                sp_tab;
  logic                lower;
  logic [7:0]          emit_char;

  // Byte classification
  assign lower  = (in_byte >= "a") && (in_byte <= "z");
  assign sp_tab = (in_byte == CH_SP) || (in_byte == CH_TAB);
  assign up_byte = lower ? (in_byte - 8'd32) : in_byte;

  assign st.is_crlf  = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign st.is_sub   = (in_byte == CH_SUB);
  assign st.is_semi  = (in_byte == CH_SEMI);
  assign st.is_eq    = (in_byte == CH_EQ);
  assign st.is_blank = sp_tab || st.is_crlf;
  assign st.is_name  = lower || ((in_byte >= "A") && (in_byte <= "Z")) ||
                       ((in_byte >= "0") && (in_byte <= "9")) || (in_byte == CH_US);

  assign st.name_full   = (name_len_r == NAME_FULL_LEN);
  assign st.value_empty = (value_len_r == '0);
  assign st.value_full  = (value_len_r == VALUE_FULL_LEN);
  assign st.name_last   = ((idx_r + IDX_W'(1)) == IDX_W'(name_len_r));
  assign st.value_last  = ((idx_r + IDX_W'(1)) == IDX_W'(vtrim_r));
  assign st.value_none  = (vtrim_r == '0);
  assign st.out_free    = !out_valid_r || out_ready;

  // Name store
  always_ff @(posedge clk) begin
    if (cmd.name_first) begin
      name_mem[0] <= up_byte;
    end else if (cmd.name_app) begin
      name_mem[name_len_r[NAME_AW-1:0]] <= up_byte;
    end
    if (cmd.ph == PH_NAME) begin
      name_rd_r <= name_mem[idx_r[NAME_AW-1:0]];
    end
  end

  // Value store
  always_ff @(posedge clk) begin
    if (cmd.value_app) begin
      value_mem[value_len_r[VALUE_AW-1:0]] <= in_byte;
    end
    if (cmd.ph == PH_VAL) begin
      value_rd_r <= value_mem[idx_r[VALUE_AW-1:0]];
    end
  end

  // Lengths and emit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r  <= '0;
      value_len_r <= '0;
      vtrim_r     <= '0;
      idx_r       <= '0;
    end else begin
      if (cmd.name_first) begin
        name_len_r <= NAME_LW'(1);
      end else if (cmd.name_app) begin
        name_len_r <= name_len_r + NAME_LW'(1);
      end
      if (cmd.value_clr) begin
        value_len_r <= '0;
        vtrim_r     <= '0;
      end else if (cmd.value_app) begin
        value_len_r <= value_len_r + VALUE_LW'(1);
        if (!sp_tab) begin
          vtrim_r <= value_len_r + VALUE_LW'(1);
        end
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Emit char select
  always_comb begin
    unique case (cmd.ph)
      PH_NAME: emit_char = name_rd_r;
      PH_EQ:   emit_char = CH_EQ;
      PH_VAL:  emit_char = value_rd_r;
      PH_CR:   emit_char = CH_CR;
      default: emit_char = CH_LF;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= emit_char;
      out_last_r <= (cmd.ph == PH_LF);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

FILE: hw/rtl/kvlp_ctrl.sv
// ----------------------------------------------------------------------------
// kvlp_ctrl
// Controller: line parse mode per accepted beat and the emit sequencer that
// walks name, '=', value, CR, LF into the output register.
// ----------------------------------------------------------------------------
module kvlp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  input  kvlp_pkg::kvlp_stat_t st,
  output kvlp_pkg::kvlp_cmd_t  cmd
);
  import kvlp_pkg::*;

  // Parse modes
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_NAME   = 3'd1;
  localparam logic [2:0] MODE_GAP    = 3'd2;
  localparam logic [2:0] MODE_VALUE  = 3'd3;
  localparam logic [2:0] MODE_CMT    = 3'd4;
  localparam logic [2:0] MODE_IGNORE = 3'd5;

  // Sequencer states
  localparam logic [1:0] SQ_PARSE = 2'd0;
  localparam logic [1:0] SQ_RD    = 2'd1;
  localparam logic [1:0] SQ_WR    = 2'd2;

  logic [2:0] mode_r, mode_nxt;
  logic [1:0] sq_r, sq_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       accept;
  logic       flush;    // beat ends a line and may emit
  logic       name_first;
  logic       name_app;
  logic       value_clr;
  logic       value_app;
  logic       idx_clr;
  logic       idx_inc;
  logic       out_load;

  assign in_ready = (sq_r == SQ_PARSE);
  assign accept   = in_valid && in_ready;

  // Per-beat parse decisions
  always_comb begin
    mode_nxt   = mode_r;
    flush      = 1'b0;
    name_first = 1'b0;
    name_app   = 1'b0;
    value_clr  = 1'b0;
    value_app  = 1'b0;
    if (accept) begin
      priority if (in_kind) begin
        flush    = 1'b1;
        mode_nxt = MODE_START;
      end else if (mode_r == MODE_IGNORE) begin
        mode_nxt = MODE_IGNORE;
      end else if (st.is_sub) begin
        flush    = 1'b1;
        mode_nxt = MODE_IGNORE;
      end else if (mode_r == MODE_CMT) begin
        if (st.is_crlf) begin
          mode_nxt = MODE_START;
        end
      end else if (st.is_crlf) begin
        flush    = 1'b1;
        mode_nxt = MODE_START;
      end else begin
        unique case (mode_r)
          MODE_START: begin
            if (st.is_semi) begin
              mode_nxt = MODE_CMT;
            end else if (st.is_name) begin
              name_first = 1'b1;
              mode_nxt   = MODE_NAME;
            end
          end
          MODE_NAME: begin
            if (st.is_eq) begin
              value_clr = 1'b1;
              mode_nxt  = MODE_VALUE;
            end else if (st.is_blank) begin
              mode_nxt = MODE_GAP;
            end else if (st.is_name && !st.name_full) begin
              name_app = 1'b1;
            end
          end
          MODE_GAP: begin
            if (st.is_eq) begin
              value_clr = 1'b1;
              mode_nxt  = MODE_VALUE;
            end else if (!st.is_blank) begin
              mode_nxt = MODE_START;
            end
          end
          MODE_VALUE: begin
            // leading blanks dropped, overflow dropped
            if (!(st.value_empty && st.is_blank) && !st.value_full) begin
              value_app = 1'b1;
            end
          end
          default: mode_nxt = MODE_START;
        endcase
      end
    end
  end

  // Emit sequencer
  always_comb begin
    sq_nxt   = sq_r;
    ph_nxt   = ph_r;
    idx_clr  = 1'b0;
    idx_inc  = 1'b0;
    out_load = 1'b0;
    unique case (sq_r)
      SQ_PARSE: begin
        if (flush && (mode_r == MODE_VALUE)) begin
          sq_nxt  = SQ_RD;
          ph_nxt  = PH_NAME;
          idx_clr = 1'b1;
        end
      end
      SQ_RD: sq_nxt = SQ_WR;
      SQ_WR: begin
        if (st.out_free) begin
          out_load = 1'b1;
          sq_nxt   = SQ_RD;
          unique case (ph_r)
            PH_NAME: begin
              if (st.name_last) begin
                idx_clr = 1'b1;
                ph_nxt  = PH_EQ;
              end else begin
                idx_inc = 1'b1;
              end
            end
            PH_EQ:   ph_nxt = st.value_none ? PH_CR : PH_VAL;
            PH_VAL: begin
              if (st.value_last) begin
                ph_nxt = PH_CR;
              end else begin
                idx_inc = 1'b1;
              end
            end
            PH_CR:   ph_nxt = PH_LF;
            default: sq_nxt = SQ_PARSE;
          endcase
        end
      end
      default: sq_nxt = SQ_PARSE;
    endcase
  end

  // Command bundle to the datapath
  assign cmd = '{
    name_first: name_first,
    name_app:   name_app,
    value_clr:  value_clr,
    value_app:  value_app,
    idx_clr:    idx_clr,
    idx_inc:    idx_inc,
    out_load:   out_load,
    ph:         ph_r
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      sq_r   <= SQ_PARSE;
      ph_r   <= PH_NAME;
    end else begin
      mode_r <= mode_nxt;
      sq_r   <= sq_nxt;
      ph_r   <= ph_nxt;
    end
  end

  // Checks
  a_load_in_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (sq_r == SQ_WR))
    else $error("output load outside write state");

  a_lf_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (ph_r == PH_LF)) |=> (sq_r == SQ_PARSE))
    else $error("emit did not end after LF");

  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == SQ_RD) |=> (sq_r == SQ_WR))
    else $error("read state not followed by write state");

  a_emit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r != SQ_PARSE) |-> ((mode_r == MODE_START) || (mode_r == MODE_IGNORE)))
    else $error("parse mode not settled during emit");

endmodule

FILE: hw/rtl/key_value_line_parser.sv
// ----------------------------------------------------------------------------
// key_value_line_parser
// Parses NAME=value text lines one byte per beat and emits clean lines.
// ----------------------------------------------------------------------------
// Input channel in_bus: one beat per text byte (kind 0) or an end-of-file
// marker (kind 1). Output channel out_bus: one beat per byte of the
// formatted line NAME=value CR LF; last is high on the closing LF.
// Bytes that do not end a line are taken one per cycle. A line ending, a
// 0x1A byte or an end-of-file beat that closes a valid pair starts the
// emit sequencer; in_bus.ready stays low while it runs. For each output
// byte the sequencer passes a read state, which fills the store read
// register, then a write state, which loads the output register; a pair
// with N name and V kept value bytes holds the input for all N+V+3
// output bytes. When out_bus.ready is low the output register holds its
// beat and the sequencer waits. The output register separates the sides,
// so the next input beat is taken while the final LF still waits. Reset
// returns the parser to line start with an empty output register; the
// name and value stores need no clearing.
// ----------------------------------------------------------------------------
module key_value_line_parser (
  input  logic              clk,
  input  logic              rst_n,
  kvlp_in_if.sink           in_bus,
  kvlp_out_if.source        out_bus
);
  import kvlp_pkg::*;

  kvlp_cmd_t  cmd;
  kvlp_stat_t st;

  kvlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_kind  (in_bus.kind),
    .in_ready (in_bus.ready),
    .st       (st),
    .cmd      (cmd)
  );

  kvlp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_bus.in_byte),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_char  (out_bus.out_char),
    .out_last  (out_bus.last)
  );

endmodule
